/* rtl/tlpt_pkg.sv */
// Shared widths, codes and entry bit masks for the two-level page table mapper.
package tlpt_pkg;

  localparam int POOL_TABLES = 64;
  localparam int TBL_WORDS   = 1024;
  localparam int IDX_W       = 10;
  localparam int WORD_W      = 32;
  localparam int FRAME_W     = 20;
  localparam int OFS_W       = 12;
  localparam int FUNC_W      = 2;
  localparam int TID_W       = 7;
  localparam int PERM_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int NT_W        = 6;

  localparam int POOL_W      = $clog2(POOL_TABLES);
  localparam int NF_W        = $clog2(POOL_TABLES + 1);
  localparam int SEL_W       = $clog2(POOL_TABLES + 1);
  localparam int ADDR_W      = SEL_W + IDX_W;
  localparam int STORE_DEPTH = (POOL_TABLES + 1) * TBL_WORDS;

  localparam logic [TID_W-1:0] ROOT_ID  = TID_W'(64);
  localparam logic [SEL_W-1:0] ROOT_SEL = SEL_W'(POOL_TABLES);
  localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(TBL_WORDS - 1);

  // function codes
  localparam logic [FUNC_W-1:0] FN_MAP    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CONFLICT  = 2'd3;

  // entry flag masks (low 12 bits of an entry)
  localparam logic [OFS_W-1:0] F_V = 12'h001;
  localparam logic [OFS_W-1:0] F_W = 12'h002;
  localparam logic [OFS_W-1:0] F_U = 12'h004;
  localparam logic [OFS_W-1:0] F_A = 12'h020;
  localparam logic [OFS_W-1:0] F_D = 12'h040;

  localparam int BIT_V = 0;
  localparam int BIT_W = 1;
  localparam int BIT_U = 2;

endpackage

/* rtl/tlpt_chan_if.sv */
// Valid/ready channel interfaces for requests, results and configuration writes.
interface tlpt_req_if import tlpt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [TID_W-1:0]    table_id;
  logic [WORD_W-1:0]   virt_addr;
  logic [WORD_W-1:0]   phys_addr;
  logic [PERM_W-1:0]   perm;

  modport source (output valid, func, table_id, virt_addr, phys_addr, perm, input ready);
  modport sink   (input valid, func, table_id, virt_addr, phys_addr, perm, output ready);
endinterface

interface tlpt_rsp_if import tlpt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                present;
  logic                user;
  logic                writable;
  logic [FRAME_W-1:0]  frame;
  logic                access_ok;
  logic [NT_W-1:0]     new_table;

  modport source (output valid, status, present, user, writable, frame, access_ok, new_table,
                  input ready);
  modport sink   (input valid, status, present, user, writable, frame, access_ok, new_table,
                  output ready);
endinterface

interface tlpt_cfg_if import tlpt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] pool_base_frame;

  modport source (output valid, pool_base_frame, input ready);
  modport sink   (input valid, pool_base_frame, output ready);
endinterface

/* rtl/tlpt_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/two_level_page_table_mapper.sv */
// A lookup reads the directory entry, then the leaf entry if that is valid; a map also writes
// the leaf, after a directory write for a user mapping. Failed walks end early; a misaligned
// map, unused func or empty-pool allocate ends in idle. A good allocate, or a map needing a
// leaf table, zeroes the new table one store write a cycle. One request in flight; the next is
// taken once the result register is free or draining. On reset a pass zeroes the root table,
// with in_req.ready low; config writes are taken. pool_base_frame, next free table reset to 0.
module two_level_page_table_mapper import tlpt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  tlpt_req_if.sink     in_req,
  tlpt_rsp_if.source   out_rsp,
  tlpt_cfg_if.sink     cfg_wr
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_LEAF,
    S_LEAFW,
    S_SWEEP
  } state_t;

  state_t state_r, state_nxt;

  logic [FRAME_W-1:0]  pool_base_r;
  logic [NF_W-1:0]     next_free_r, next_free_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [POOL_W-1:0]   cid_r, cid_nxt;
  logic                sweep_leaf_r, sweep_leaf_nxt;

  // latched request fields
  logic [FUNC_W-1:0]   func_r;
  logic [ADDR_W-1:0]   dir_addr_r;
  logic [IDX_W-1:0]    lidx_r;
  logic [FRAME_W-1:0]  pa_frame_r;
  logic [PERM_W-1:0]   perm_r;
  logic [WORD_W-1:0]   dir_word_r;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, res_status;
  logic                present_r, res_present;
  logic                user_r, res_user;
  logic                writable_r, res_writable;
  logic [FRAME_W-1:0]  frame_r, res_frame;
  logic                access_ok_r, res_access_ok;
  logic [NT_W-1:0]     new_table_r, res_new_table;
  logic                finish;

  // store port
  logic                ram_en, ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                in_acc;
  logic [SEL_W-1:0]    in_sel;
  logic [ADDR_W-1:0]   in_dir_addr;
  logic                in_misaligned;
  logic                exhausted;
  logic [POOL_W-1:0]   free_cid;
  logic [FRAME_W-1:0]  dir_rel;
  logic                dir_child;
  logic [POOL_W-1:0]   dir_cid;
  logic [WORD_W-1:0]   new_dir_word;
  logic [OFS_W-1:0]    leaf_flags;
  logic [WORD_W-1:0]   leaf_word;

  tlpt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_acc       = in_req.valid && in_req.ready;

  assign in_sel = (in_req.table_id != ROOT_ID && 32'(in_req.table_id) < POOL_TABLES) ?
                  SEL_W'(in_req.table_id) : ROOT_SEL;
  assign in_dir_addr   = {in_sel, in_req.virt_addr[31:22]};
  assign in_misaligned = (in_req.virt_addr[OFS_W-1:0] != '0) ||
                         (in_req.phys_addr[OFS_W-1:0] != '0);

  assign exhausted = 32'(next_free_r) >= POOL_TABLES;
  assign free_cid  = POOL_W'(next_free_r);

  // directory word in the read register
  assign dir_rel   = ram_rdata[WORD_W-1:OFS_W] - pool_base_r;
  assign dir_child = 32'(dir_rel) < POOL_TABLES;
  assign dir_cid   = POOL_W'(dir_rel);

  assign new_dir_word = {FRAME_W'(pool_base_r + FRAME_W'(free_cid)),
                         F_V | F_W | (perm_r[1] ? F_U : '0)};

  always_comb begin
    leaf_flags = F_V | F_A | F_D;
    if (perm_r[1]) begin
      leaf_flags = leaf_flags | F_U | (perm_r[0] ? F_W : '0);
    end else begin
      leaf_flags = leaf_flags | F_W;
    end
  end
  assign leaf_word = {pa_frame_r, leaf_flags};

  always_comb begin
    state_nxt      = state_r;
    next_free_nxt  = next_free_r;
    cnt_nxt        = cnt_r;
    cid_nxt        = cid_r;
    sweep_leaf_nxt = sweep_leaf_r;
    finish         = 1'b0;
    res_status     = ST_OK;
    res_present    = 1'b0;
    res_user       = 1'b0;
    res_writable   = 1'b0;
    res_frame      = '0;
    res_access_ok  = 1'b0;
    res_new_table  = '0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = dir_addr_r;
    ram_wdata      = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = {ROOT_SEL, cnt_r};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == IDX_MAX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_req.func == FN_MAP && in_misaligned) begin
            finish     = 1'b1;
            res_status = ST_MISALIGN;
          end else if (in_req.func == FN_MAP || in_req.func == FN_LOOKUP) begin
            ram_en    = 1'b1;
            ram_addr  = in_dir_addr;
            state_nxt = S_DIR;
          end else if (in_req.func == FN_ALLOC) begin
            if (exhausted) begin
              finish     = 1'b1;
              res_status = ST_EXHAUSTED;
            end else begin
              cid_nxt        = free_cid;
              next_free_nxt  = NF_W'(next_free_r + 1'b1);
              sweep_leaf_nxt = 1'b0;
              cnt_nxt        = '0;
              state_nxt      = S_SWEEP;
            end
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_DIR: begin
        if (func_r == FN_LOOKUP) begin
          if (ram_rdata[BIT_V] && dir_child) begin
            ram_en    = 1'b1;
            ram_addr  = {SEL_W'(dir_cid), lidx_r};
            cid_nxt   = dir_cid;
            state_nxt = S_LEAF;
          end else begin
            finish = 1'b1;
          end
        end else if (!ram_rdata[BIT_V]) begin
          if (exhausted) begin
            finish     = 1'b1;
            res_status = ST_EXHAUSTED;
          end else begin
            // install the directory entry, then zero the new leaf table
            ram_en         = 1'b1;
            ram_we         = 1'b1;
            ram_addr       = dir_addr_r;
            ram_wdata      = new_dir_word;
            cid_nxt        = free_cid;
            next_free_nxt  = NF_W'(next_free_r + 1'b1);
            sweep_leaf_nxt = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = S_SWEEP;
          end
        end else if (!dir_child) begin
          finish     = 1'b1;
          res_status = ST_EXHAUSTED;
        end else begin
          ram_en    = 1'b1;
          ram_addr  = {SEL_W'(dir_cid), lidx_r};
          cid_nxt   = dir_cid;
          state_nxt = S_LEAF;
        end
      end
      S_LEAF: begin
        if (func_r == FN_LOOKUP) begin
          finish        = 1'b1;
          res_present   = ram_rdata[BIT_V];
          res_user      = ram_rdata[BIT_U];
          res_writable  = ram_rdata[BIT_W];
          res_frame     = ram_rdata[WORD_W-1:OFS_W];
          res_access_ok = ram_rdata[BIT_V] && ram_rdata[BIT_U] &&
                          (!perm_r[0] || ram_rdata[BIT_W]);
        end else if (ram_rdata[BIT_V] && ram_rdata[WORD_W-1:OFS_W] != pa_frame_r) begin
          finish     = 1'b1;
          res_status = ST_CONFLICT;
        end else if (perm_r[1]) begin
          // directory first: the leaf write must win if both hit one word
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = dir_addr_r;
          ram_wdata = dir_word_r | {{FRAME_W{1'b0}}, F_U | F_W};
          state_nxt = S_LEAFW;
        end else begin
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          ram_addr  = {SEL_W'(cid_r), lidx_r};
          ram_wdata = leaf_word;
          finish    = 1'b1;
        end
      end
      S_LEAFW: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = {SEL_W'(cid_r), lidx_r};
        ram_wdata = leaf_word;
        finish    = 1'b1;
      end
      S_SWEEP: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = {SEL_W'(cid_r), cnt_r};
        ram_wdata = (sweep_leaf_r && cnt_r == lidx_r) ? leaf_word : '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == IDX_MAX) begin
          finish = 1'b1;
          if (!sweep_leaf_r) begin
            res_new_table = NT_W'(cid_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
    end
  end

  // state, control and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      next_free_r  <= '0;
      cnt_r        <= '0;
      cid_r        <= '0;
      sweep_leaf_r <= 1'b0;
      out_valid_r  <= 1'b0;
      status_r     <= ST_OK;
      present_r    <= 1'b0;
      user_r       <= 1'b0;
      writable_r   <= 1'b0;
      frame_r      <= '0;
      access_ok_r  <= 1'b0;
      new_table_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      next_free_r  <= next_free_nxt;
      cnt_r        <= cnt_nxt;
      cid_r        <= cid_nxt;
      sweep_leaf_r <= sweep_leaf_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
        status_r    <= res_status;
        present_r   <= res_present;
        user_r      <= res_user;
        writable_r  <= res_writable;
        frame_r     <= res_frame;
        access_ok_r <= res_access_ok;
        new_table_r <= res_new_table;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      pool_base_r <= cfg_wr.pool_base_frame;
    end
  end

  // hold request fields for the walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_req.func;
      dir_addr_r <= in_dir_addr;
      lidx_r     <= in_req.virt_addr[21:12];
      pa_frame_r <= in_req.phys_addr[WORD_W-1:OFS_W];
      perm_r     <= in_req.perm;
    end
    if (state_r == S_DIR) begin
      dir_word_r <= ram_rdata;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.present   = present_r;
  assign out_rsp.user      = user_r;
  assign out_rsp.writable  = writable_r;
  assign out_rsp.frame     = frame_r;
  assign out_rsp.access_ok = access_ok_r;
  assign out_rsp.new_table = new_table_r;

endmodule

/* rtl/tlpt_checker.sv */
// Port-level assertions for the page table mapper, bound to its top level.
module tlpt_checker import tlpt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_present,
  input logic                out_user,
  input logic                out_writable,
  input logic [FRAME_W-1:0]  out_frame,
  input logic                out_access_ok,
  input logic [NT_W-1:0]     out_new_table
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_frame) &&
    $stable(out_new_table))
    else $error("result changed while stalled");

  // an access grant needs a present user page on a good walk
  a_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_ok |-> out_present && out_user && out_status == ST_OK)
    else $error("access granted without present user page");

  // a failed request reports nothing else
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_present && !out_user && !out_writable &&
    out_frame == '0 && !out_access_ok && out_new_table == '0)
    else $error("failed request carries lookup or table fields");

  // a handed-out table comes only from a clean allocate
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_table != '0 |-> out_status == ST_OK && !out_present && out_frame == '0)
    else $error("table id mixed with other results");

  // requests are blocked right after reset, while the root table is cleared
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken right after reset");

endmodule

bind two_level_page_table_mapper tlpt_checker u_tlpt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_req.ready),
  .out_valid     (out_rsp.valid),
  .out_ready     (out_rsp.ready),
  .out_status    (out_rsp.status),
  .out_present   (out_rsp.present),
  .out_user      (out_rsp.user),
  .out_writable  (out_rsp.writable),
  .out_frame     (out_rsp.frame),
  .out_access_ok (out_rsp.access_ok),
  .out_new_table (out_rsp.new_table)
);

/* verif/page_table_checker.sv */
`timescale 1ns / 100ps
// Checker for the page table mapper: mirrors the table store, predicts each result, compares.
module page_table_checker import tlpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tlpt_req_if  req,
  tlpt_rsp_if  rsp,
  tlpt_cfg_if  cfg,
  output int   fails,
  output int   pending
);

  localparam int PERM_WRITE = 0;
  localparam int PERM_USER  = 1;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                present;
    logic                user;
    logic                writable;
    logic [FRAME_W-1:0]  frame;
    logic                access_ok;
    logic [NT_W-1:0]     new_table;
  } walk_result_t;

  // All words start at zero; reset is applied once, so the root table is clear.
  bit [WORD_W-1:0]  store_mirror [STORE_DEPTH];
  bit [FRAME_W-1:0] base_frame;
  int unsigned      next_free;
  walk_result_t     expected_q [$];

  task automatic report_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  function automatic int unsigned dir_slot(logic [TID_W-1:0] tid, logic [WORD_W-1:0] va);
    int unsigned tbl;
    tbl = (tid != ROOT_ID && tid < POOL_TABLES) ? int'(tid) : POOL_TABLES;
    return tbl * TBL_WORDS + va[OFS_W+IDX_W +: IDX_W];
  endfunction

  // A directory entry is usable only when its frame lands inside the pool window.
  function automatic bit pool_child(logic [WORD_W-1:0] dir, output int unsigned cid);
    logic [FRAME_W-1:0] rel;
    rel = dir[OFS_W +: FRAME_W] - base_frame;
    cid = 32'(rel);
    return rel < POOL_TABLES;
  endfunction

  function automatic bit claim_table(output int unsigned cid);
    cid = 0;
    if (next_free >= POOL_TABLES)
      return 1'b0;
    cid = next_free;
    next_free++;
    for (int i = 0; i < TBL_WORDS; i++)
      store_mirror[cid * TBL_WORDS + i] = '0;
    return 1'b1;
  endfunction

  function automatic walk_result_t walk_request(logic [FUNC_W-1:0] fn, logic [TID_W-1:0] tid,
      logic [WORD_W-1:0] va, logic [WORD_W-1:0] pa, logic [PERM_W-1:0] perm);
    walk_result_t      r;
    int unsigned       dslot, lslot, cid;
    logic [WORD_W-1:0] dir, leaf;
    logic [OFS_W-1:0]  flags;
    r = '{default: '0};
    dslot = dir_slot(tid, va);
    dir = store_mirror[dslot];
    case (fn)
      FN_MAP: begin
        if (va[OFS_W-1:0] != '0 || pa[OFS_W-1:0] != '0) begin
          r.status = ST_MISALIGN;
          return r;
        end
        if (!dir[BIT_V]) begin
          if (!claim_table(cid)) begin
            r.status = ST_EXHAUSTED;
            return r;
          end
          dir = {base_frame + FRAME_W'(cid), F_V | F_W};
          store_mirror[dslot] = dir;
        end else if (!pool_child(dir, cid)) begin
          r.status = ST_EXHAUSTED;
          return r;
        end
        lslot = cid * TBL_WORDS + va[OFS_W +: IDX_W];
        leaf = store_mirror[lslot];
        if (leaf[BIT_V] && leaf[OFS_W +: FRAME_W] != pa[OFS_W +: FRAME_W]) begin
          r.status = ST_CONFLICT;
          return r;
        end
        flags = F_V | F_A | F_D;
        if (perm[PERM_USER]) begin
          store_mirror[dslot] = dir | {FRAME_W'(0), F_U | F_W};
          flags |= F_U;
          if (perm[PERM_WRITE])
            flags |= F_W;
        end else begin
          flags |= F_W;
        end
        store_mirror[lslot] = {pa[OFS_W +: FRAME_W], flags};
        r.status = ST_OK;
      end
      FN_LOOKUP: begin
        if (dir[BIT_V] && pool_child(dir, cid)) begin
          leaf = store_mirror[cid * TBL_WORDS + va[OFS_W +: IDX_W]];
          r.present   = leaf[BIT_V];
          r.user      = leaf[BIT_U];
          r.writable  = leaf[BIT_W];
          r.frame     = leaf[OFS_W +: FRAME_W];
          r.access_ok = leaf[BIT_V] && leaf[BIT_U] && (!perm[PERM_WRITE] || leaf[BIT_W]);
        end
      end
      FN_ALLOC: begin
        if (claim_table(cid))
          r.new_table = NT_W'(cid);
        else
          r.status = ST_EXHAUSTED;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : track
    walk_result_t want;
    if (!rst_n) begin
      base_frame = '0;
      next_free  = 0;
      expected_q.delete();
      fails   = 0;
      pending <= 0;
    end else begin
      // Compare first: a result at this edge belongs to an earlier request.
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(rsp.status), 32'(want.status));
          check_field("present", 32'(rsp.present), 32'(want.present));
          check_field("user", 32'(rsp.user), 32'(want.user));
          check_field("writable", 32'(rsp.writable), 32'(want.writable));
          check_field("frame", 32'(rsp.frame), 32'(want.frame));
          check_field("access_ok", 32'(rsp.access_ok), 32'(want.access_ok));
          check_field("new_table", 32'(rsp.new_table), 32'(want.new_table));
        end
      end
      if (cfg.valid && cfg.ready)
        base_frame = cfg.pool_base_frame;
      if (req.valid && req.ready)
        expected_q.push_back(walk_request(req.func, req.table_id, req.virt_addr,
                                          req.phys_addr, req.perm));
      pending <= expected_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Testbench top for the page table mapper: clock, reset, request and result pacing, verdict.
module testbench;
  import tlpt_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int ROOTS_PREALLOC = 4;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 170;
  localparam int HOLD_CYCLES    = 200;
  localparam int IDLE_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 1100;

  logic clk = 1'b0;
  logic rst_n;
  int   fails;
  int   pending;
  int   idle_cycles;
  bit   hold_rsp;
  bit   send_burst;

  logic [IDX_W-1:0]   dir_pick [4];
  logic [IDX_W-1:0]   leaf_pick [8];
  logic [FRAME_W-1:0] frame_pick [6];

  tlpt_req_if req_ch();
  tlpt_rsp_if rsp_ch();
  tlpt_cfg_if cfg_ch();

  two_level_page_table_mapper dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  page_table_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // Bases differ by at least a pool's width, or wrap up by one from 0xfffff to 0, so an
  // old directory entry either leaves the pool window or lands on a table already handed out.
  function automatic logic [FRAME_W-1:0] phase_base(int p);
    case (p)
      0:       return 20'hfffff;
      2, 5:    return 20'h80000;
      3:       return 20'h12345;
      default: return 20'h00000;
    endcase
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [TID_W-1:0] tid,
      input logic [WORD_W-1:0] va, input logic [WORD_W-1:0] pa, input logic [PERM_W-1:0] perm);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0)
      send_burst = !send_burst;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= fn;
    req_ch.table_id  <= tid;
    req_ch.virt_addr <= va;
    req_ch.phys_addr <= pa;
    req_ch.perm      <= perm;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_pool_base(input logic [FRAME_W-1:0] value);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.pool_base_frame <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic pick_phase_targets();
    dir_pick[0] = '0;
    dir_pick[1] = IDX_MAX;
    dir_pick[2] = IDX_W'($urandom_range(0, IDX_MAX));
    dir_pick[3] = IDX_W'($urandom_range(0, IDX_MAX));
    foreach (leaf_pick[k])
      leaf_pick[k] = IDX_W'($urandom_range(0, IDX_MAX));
    frame_pick[0] = '0;
    frame_pick[1] = '1;
    // Keep random frames clear of every base window so a leaf read as a directory stays safe.
    for (int k = 2; k < 6; k++)
      frame_pick[k] = FRAME_W'($urandom_range(20'h13000, 20'h7ffff));
  endtask

  task automatic send_random_item();
    int sel;
    logic [FUNC_W-1:0] fn;
    logic [TID_W-1:0]  tid;
    logic [WORD_W-1:0] va, pa;
    sel = $urandom_range(0, 99);
    fn = (sel < 48) ? FN_MAP : (sel < 92) ? FN_LOOKUP : (sel < 96) ? FN_ALLOC : FN_UNUSED;
    sel = $urandom_range(0, 9);
    if (sel < 6)
      tid = ROOT_ID;
    else if (sel < 9)
      tid = TID_W'($urandom_range(0, ROOTS_PREALLOC - 1));
    else
      tid = TID_W'($urandom_range(int'(ROOT_ID) + 1, 127));
    va = {dir_pick[$urandom_range(0, 3)], leaf_pick[$urandom_range(0, 7)], OFS_W'(0)};
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      va = $urandom;
      // A stray aligned map would burn a pool table on a random directory slot.
      if (fn == FN_MAP)
        va[0] = 1'b1;
    end else if (sel == 1) begin
      va[OFS_W-1:0] = OFS_W'($urandom_range(1, 12'hfff));
    end
    if ($urandom_range(0, 19) == 0)
      pa = {FRAME_W'($urandom_range(0, 20'hfffff)), OFS_W'($urandom_range(1, 12'hfff))};
    else
      pa = {frame_pick[$urandom_range(0, 5)], OFS_W'(0)};
    send_request(fn, tid, va, pa, PERM_W'($urandom_range(0, 3)));
  endtask

  // Result side: random stalls, bursts with none, and one long hold-off on request.
  initial begin : result_pacing
    int stall;
    bit burst;
    burst = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end
      stall = burst ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 39) == 0)
        burst = !burst;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL two_level_page_table_mapper");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n                  <= 1'b0;
    req_ch.valid           <= 1'b0;
    req_ch.func            <= FN_MAP;
    req_ch.table_id        <= '0;
    req_ch.virt_addr       <= '0;
    req_ch.phys_addr       <= '0;
    req_ch.perm            <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.pool_base_frame <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_pool_base(phase_base(0));

    // Hand out the pool tables that later serve as roots.
    repeat (ROOTS_PREALLOC)
      send_request(FN_ALLOC, ROOT_ID, '0, '0, '0);
    send_request(FN_MAP, ROOT_ID, 32'h0000_0000, 32'h0000_0000, 2'd0);
    send_request(FN_MAP, ROOT_ID, 32'hffff_f000, 32'hffff_f000, 2'd3);
    send_request(FN_MAP, ROOT_ID, 32'hffff_f000, 32'h0000_1000, 2'd3);
    send_request(FN_MAP, ROOT_ID, 32'hffff_f000, 32'hffff_f000, 2'd2);
    send_request(FN_MAP, ROOT_ID, 32'h0000_0fff, 32'h0000_0000, 2'd1);
    send_request(FN_MAP, ROOT_ID, 32'h0000_2000, 32'h0000_0800, 2'd1);
    send_request(FN_LOOKUP, ROOT_ID, 32'hffff_ffff, '0, 2'd1);
    send_request(FN_LOOKUP, ROOT_ID, 32'hffff_f123, '0, 2'd0);
    send_request(FN_LOOKUP, ROOT_ID, 32'h0000_0000, '0, 2'd2);
    send_request(FN_LOOKUP, ROOT_ID, 32'h0040_0000, '0, 2'd3);
    send_request(FN_LOOKUP, ROOT_ID, 32'h0000_1000, '0, 2'd0);
    send_request(FN_MAP, 7'd127, 32'h0040_1000, 32'h7fff_f000, 2'd1);
    send_request(FN_LOOKUP, 7'd65, 32'h0040_1abc, '0, 2'd3);
    send_request(FN_MAP, 7'd3, 32'h8000_0000, 32'h1234_5000, 2'd2);
    send_request(FN_LOOKUP, 7'd3, 32'h8000_0000, '0, 2'd3);
    send_request(FN_LOOKUP, 7'd0, $urandom, '0, 2'd1);
    send_request(FN_UNUSED, '1, '1, '1, '1);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        write_pool_base(phase_base(p));
      end
      pick_phase_targets();
      // Run the pool dry so maps and allocations hit the exhausted path.
      if (p == PHASES - 1)
        repeat (POOL_TABLES + 2)
          send_request(FN_ALLOC, ROOT_ID, '0, '0, '0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 60)
          hold_rsp = 1'b1;
        if (p == 2 && i == 90)
          drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("PASS two_level_page_table_mapper");
    else
      $display("FAIL two_level_page_table_mapper");
    $finish;
  end

endmodule
